// ===== sv/pidv_pkg.sv =====
package pidv_pkg;

   typedef struct packed {
      logic signed [31:0] measured_value;
      logic [31:0]        sample_time;
   } req_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic               zero_step;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_INTEG,
      ST_CLAMP,
      ST_DIV,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_SAT,
      ST_OUT
   } state_type;

   localparam int unsigned DIV_STEPS = 33;

   localparam logic [2:0] CSR_KP     = 3'd0;
   localparam logic [2:0] CSR_KI     = 3'd1;
   localparam logic [2:0] CSR_KD     = 3'd2;
   localparam logic [2:0] CSR_TARGET = 3'd3;
   localparam logic [2:0] CSR_LIMIT  = 3'd4;

   typedef struct packed {
      logic load;
      logic integ;
      logic clamp;
      logic div_start;
      logic div_step;
      logic mul_p;
      logic mul_i;
      logic mul_d;
      logic sat;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } sts_type;

endpackage

// ===== sv/pid_controller_variable_dt.sv =====
// An accepted req word passes through the prep, integrate, clamp, divide,
// multiply and saturate states to rsp_valid; a zero time step makes the
// serial divider for the derivative clear its quotient instead of dividing.
// A new word is taken only in idle, once the last rsp handshake is done.
// Reset (synchronous, active high): gains and target go to zero, the
// integral limit to all ones, integral, previous error and last time to zero.
module pid_controller_variable_dt (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pidv_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pidv_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data
);

   logic signed [31:0] kp_ff, ki_ff, kd_ff, target_ff;
   logic [30:0]        limit_ff;
   pidv_pkg::cmd_type  cmd;
   pidv_pkg::sts_type  sts;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff     <= '0;
         ki_ff     <= '0;
         kd_ff     <= '0;
         target_ff <= '0;
         limit_ff  <= '1;
      end else if (csr_write) begin
         case (csr_index)
            pidv_pkg::CSR_KP:     kp_ff     <= csr_data;
            pidv_pkg::CSR_KI:     ki_ff     <= csr_data;
            pidv_pkg::CSR_KD:     kd_ff     <= csr_data;
            pidv_pkg::CSR_TARGET: target_ff <= csr_data;
            pidv_pkg::CSR_LIMIT:  limit_ff  <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   pidv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pidv_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .sts    (sts),
      .req    (req_data),
      .kp     (kp_ff),
      .ki     (ki_ff),
      .kd     (kd_ff),
      .target (target_ff),
      .limit  (limit_ff),
      .rsp    (rsp_data)
   );

endmodule

// ===== sv/pidv_ctrl.sv =====
module pidv_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  pidv_pkg::sts_type  sts,
   output pidv_pkg::cmd_type  cmd
);

   pidv_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pidv_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pidv_pkg::ST_IDLE:  if (req_valid) state_in = pidv_pkg::ST_PREP;
         pidv_pkg::ST_PREP:  state_in = pidv_pkg::ST_INTEG;
         pidv_pkg::ST_INTEG: state_in = pidv_pkg::ST_CLAMP;
         pidv_pkg::ST_CLAMP: state_in = pidv_pkg::ST_DIV;
         pidv_pkg::ST_DIV:   if (sts.div_done) state_in = pidv_pkg::ST_MUL_P;
         pidv_pkg::ST_MUL_P: state_in = pidv_pkg::ST_MUL_I;
         pidv_pkg::ST_MUL_I: state_in = pidv_pkg::ST_MUL_D;
         pidv_pkg::ST_MUL_D: state_in = pidv_pkg::ST_SAT;
         pidv_pkg::ST_SAT:   state_in = pidv_pkg::ST_OUT;
         pidv_pkg::ST_OUT:   if (rsp_ready) state_in = pidv_pkg::ST_IDLE;
         default:            state_in = pidv_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         pidv_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         pidv_pkg::ST_PREP:  cmd.div_start = 1'b1;
         pidv_pkg::ST_INTEG: begin
            cmd.integ    = 1'b1;
            cmd.div_step = 1'b1;
         end
         pidv_pkg::ST_CLAMP: begin
            cmd.clamp    = 1'b1;
            cmd.div_step = 1'b1;
         end
         pidv_pkg::ST_DIV:   cmd.div_step = 1'b1;
         pidv_pkg::ST_MUL_P: cmd.mul_p = 1'b1;
         pidv_pkg::ST_MUL_I: cmd.mul_i = 1'b1;
         pidv_pkg::ST_MUL_D: cmd.mul_d = 1'b1;
         pidv_pkg::ST_SAT:   cmd.sat = 1'b1;
         pidv_pkg::ST_OUT:   rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

// ===== sv/pidv_dp.sv =====
module pidv_dp (
   input  logic               clock,
   input  logic               reset,
   input  pidv_pkg::cmd_type  cmd,
   output pidv_pkg::sts_type  sts,
   input  pidv_pkg::req_type  req,
   input  logic signed [31:0] kp,
   input  logic signed [31:0] ki,
   input  logic signed [31:0] kd,
   input  logic signed [31:0] target,
   input  logic [30:0]        limit,
   output pidv_pkg::rsp_type  rsp
);

   // error fits 33 bits, error*dt up to 65 bits; the clamp right after the
   // add bounds the integral to 33 bits, so no separate term limit is needed
   logic signed [32:0] err_ff, err_in;
   logic signed [32:0] prev_ff;
   logic signed [32:0] integ_ff;
   logic [31:0]        last_ff;
   logic [31:0]        dt_ff;
   logic signed [65:0] integ_raw_ff;
   logic               neg_ff;
   logic [33:0]        quo_ff, rem_ff;
   logic [5:0]         cnt_ff;
   logic signed [65:0] prod;
   logic signed [67:0] acc_ff;
   logic signed [33:0] deriv;
   logic               zero_ff;
   logic signed [31:0] drive_ff;
   logic signed [65:0] err_dt;
   logic signed [65:0] lim_pos;
   logic [34:0]        trial;
   logic signed [33:0] mul_b;
   logic signed [31:0] mul_a;
   logic signed [65:0] term;

   function automatic logic diff_in_neg(logic signed [32:0] a, logic signed [32:0] b);
      logic signed [33:0] d;
      d = 34'(a) - 34'(b);
      return d[33];
   endfunction

   function automatic logic [33:0] abs_diff(logic signed [32:0] a, logic signed [32:0] b);
      logic signed [33:0] d;
      d = 34'(a) - 34'(b);
      return d[33] ? 34'(-d) : d;
   endfunction

   assign err_in = 33'(target) - 33'(req.measured_value);
   assign err_dt = 66'(err_ff) * $signed({34'd0, dt_ff});
   assign lim_pos = 66'($signed({1'b0, limit}));
   assign trial = {rem_ff[32:0], quo_ff[33]} - {3'd0, dt_ff};
   assign deriv = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

   always_comb begin
      mul_a = kp;
      mul_b = 34'(err_ff);
      if (cmd.mul_i) begin
         mul_a = ki;
         mul_b = 34'(integ_ff);
      end else if (cmd.mul_d) begin
         mul_a = kd;
         mul_b = deriv;
      end
   end
   // 32x34 product; the derivative reaches nearly 2^33 when dt is 1 and the
   // target moved between words, so it keeps all 34 bits
   assign prod = 66'(mul_a) * 66'(mul_b);
   assign term = prod >>> 16;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         integ_ff <= '0;
         last_ff  <= '0;
      end else begin
         if (cmd.load) begin
            err_ff  <= err_in;
            dt_ff   <= req.sample_time - last_ff;
            last_ff <= req.sample_time;
         end
         if (cmd.div_start) begin
            prev_ff <= err_ff;
            zero_ff <= (dt_ff == '0);
         end
         if (cmd.integ) integ_raw_ff <= 66'(integ_ff) + err_dt;
         if (cmd.clamp) begin
            if (integ_raw_ff > lim_pos) integ_ff <= lim_pos[32:0];
            else if (integ_raw_ff < -lim_pos) integ_ff <= -(lim_pos[32:0]);
            else integ_ff <= integ_raw_ff[32:0];
         end
      end
   end

   // restoring divider, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff <= diff_in_neg(err_ff, prev_ff);
         quo_ff <= abs_diff(err_ff, prev_ff);
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step && cnt_ff != 6'(pidv_pkg::DIV_STEPS + 1)) begin
         if (zero_ff) begin
            quo_ff <= '0;
            cnt_ff <= 6'(pidv_pkg::DIV_STEPS + 1);
         end else begin
            cnt_ff <= cnt_ff + 6'd1;
            if (!trial[34]) begin
               rem_ff <= trial[33:0];
               quo_ff <= {quo_ff[32:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[32:0], quo_ff[33]};
               quo_ff <= {quo_ff[32:0], 1'b0};
            end
         end
      end
   end

   assign sts.div_done = (cnt_ff == 6'(pidv_pkg::DIV_STEPS + 1))
                         || (cnt_ff == 6'(pidv_pkg::DIV_STEPS));

   always_ff @(posedge clock) begin
      if (cmd.mul_p) acc_ff <= 68'(term);
      if (cmd.mul_i || cmd.mul_d) acc_ff <= acc_ff + 68'(term);
      if (cmd.sat) begin
         if (acc_ff > 68'sd2147483647) drive_ff <= 32'sh7fffffff;
         else if (acc_ff < -68'sd2147483648) drive_ff <= 32'sh80000000;
         else drive_ff <= acc_ff[31:0];
      end
   end

   assign rsp.drive     = drive_ff;
   assign rsp.zero_step = zero_ff;

endmodule
